// ===== rtl/core/fdc_pkg.sv =====
// Shared types, widths, constants and calibration tables of the flow
// conditioning core. No dependencies.
package fdc_pkg;

  localparam int TABLE_POINTS = 25;
  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_POINTS - 2);

  localparam int DP_W = 16;
  localparam int PER_W = 18;
  localparam int CORR_W = 17;
  localparam int FLOW_W = 16;
  localparam int ALPHA_W = 16;
  localparam int FV_W = 32;
  localparam int CAL_DP_W = 14;
  localparam int CAL_Q_W = 12;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO = 1'b1;

  localparam logic [9:0] CUTOFF_RESET = 10'd100;
  localparam logic signed [9:0] ZO_RESET = -10'sd20;
  localparam logic signed [9:0] ZO_MAX = 10'sd500;
  localparam logic signed [9:0] ZO_MIN = -10'sd500;
  localparam logic [9:0] CUTOFF_MIN = 10'd1;
  localparam logic [9:0] CUTOFF_MAX = 10'd500;
  localparam int C_W = 9;
  localparam logic [PER_W-1:0] MAX_PERIOD_US = 18'd100000;

  localparam int CP_W = 26;
  localparam int K_W = 45;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  localparam int NUM_W = 62;
  localparam int DEN_W = 46;
  localparam int QUO_W = 17;
  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic [DEN_W-1:0] TIME_SCALE_Q16 = 46'd655360000000;

  localparam int MNUM_W = 31;

  typedef struct packed {
    logic ready;
    logic load;
    logic mul1;
    logic mul2;
    logic div_alpha;
    logic alpha_take;
    logic diff;
    logic fmul;
    logic fupd;
    logic fout;
    logic scan_clr;
    logic scan_inc;
    logic mmul;
    logic div_map;
    logic map_take;
    logic x_sel;
    logic out_load;
  } fdc_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_ok;
    logic div_busy;
    logic scan_hit;
    logic out_busy;
  } fdc_sts_t;

  function automatic logic signed [CAL_DP_W-1:0] cal_dp(input logic [IDX_W-1:0] i);
    logic signed [CAL_DP_W-1:0] v;
    case (i)
      5'd0: v = -14'sd4720;
      5'd1: v = -14'sd3990;
      5'd2: v = -14'sd3330;
      5'd3: v = -14'sd2740;
      5'd4: v = -14'sd2200;
      5'd5: v = -14'sd1720;
      5'd6: v = -14'sd1260;
      5'd7: v = -14'sd890;
      5'd8: v = -14'sd580;
      5'd9: v = -14'sd340;
      5'd10: v = -14'sd155;
      5'd11: v = -14'sd40;
      5'd12: v = 14'sd0;
      5'd13: v = 14'sd55;
      5'd14: v = 14'sd168;
      5'd15: v = 14'sd366;
      5'd16: v = 14'sd623;
      5'd17: v = 14'sd955;
      5'd18: v = 14'sd1380;
      5'd19: v = 14'sd1880;
      5'd20: v = 14'sd2450;
      5'd21: v = 14'sd3075;
      5'd22: v = 14'sd3770;
      5'd23: v = 14'sd4620;
      5'd24: v = 14'sd5340;
      default: v = 14'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CAL_Q_W-1:0] cal_q(input logic [IDX_W-1:0] i);
    logic signed [CAL_Q_W-1:0] v;
    case (i)
      5'd0: v = -12'sd1210;
      5'd1: v = -12'sd1100;
      5'd2: v = -12'sd990;
      5'd3: v = -12'sd880;
      5'd4: v = -12'sd780;
      5'd5: v = -12'sd670;
      5'd6: v = -12'sd548;
      5'd7: v = -12'sd438;
      5'd8: v = -12'sd330;
      5'd9: v = -12'sd230;
      5'd10: v = -12'sd131;
      5'd11: v = -12'sd49;
      5'd12: v = 12'sd0;
      5'd13: v = 12'sd50;
      5'd14: v = 12'sd132;
      5'd15: v = 12'sd232;
      5'd16: v = 12'sd334;
      5'd17: v = 12'sd442;
      5'd18: v = 12'sd552;
      5'd19: v = 12'sd673;
      5'd20: v = 12'sd770;
      5'd21: v = 12'sd880;
      5'd22: v = 12'sd985;
      5'd23: v = 12'sd1090;
      5'd24: v = 12'sd1200;
      default: v = 12'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/fdc_in_if.sv =====
// Sample channel: valid/ready plus raw pressure and sample period.
// Depends on fdc_pkg.
interface fdc_in_if import fdc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DP_W-1:0] dp_sample;
  logic [PER_W-1:0] period_us;
  modport source(output valid, dp_sample, period_us, input ready);
  modport sink(input valid, dp_sample, period_us, output ready);
endinterface

// ===== rtl/core/fdc_out_if.sv =====
// Result channel: valid/ready plus filtered pressure, flows and alpha.
// Depends on fdc_pkg.
interface fdc_out_if import fdc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DP_W-1:0] dp_filtered;
  logic signed [CORR_W-1:0] dp_corrected;
  logic signed [FLOW_W-1:0] flow_filtered;
  logic signed [FLOW_W-1:0] flow_raw;
  logic [ALPHA_W-1:0] alpha_q16;
  modport source(output valid, dp_filtered, dp_corrected, flow_filtered, flow_raw,
                 alpha_q16, input ready);
  modport sink(input valid, dp_filtered, dp_corrected, flow_filtered, flow_raw,
               alpha_q16, output ready);
endinterface

// ===== rtl/core/fdc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by alpha and
// calibration interpolation. Depends on fdc_pkg.
module fdc_div import fdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign ge = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = DEN_W'(num[NUM_W-1:QUO_W]);
      den_nxt = den;
      lo_nxt = num[QUO_W-1:0];
      cnt_nxt = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      lo_nxt = {lo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r <= lo_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign quo = lo_r;

endmodule

// ===== rtl/core/fdc_dpath.sv =====
// Datapath: config registers, alpha, IIR filter state, table scan,
// interpolation and output register. Depends on fdc_pkg and fdc_div.
module fdc_dpath import fdc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fdc_cmd_t                     cmd,
  output fdc_sts_t                     sts,
  input  logic                         in_valid,
  input  logic signed [DP_W-1:0]       in_dp_sample,
  input  logic [PER_W-1:0]             in_period_us,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [DP_W-1:0]       out_dp_filtered,
  output logic signed [CORR_W-1:0]     out_dp_corrected,
  output logic signed [FLOW_W-1:0]     out_flow_filtered,
  output logic signed [FLOW_W-1:0]     out_flow_raw,
  output logic [ALPHA_W-1:0]           out_alpha_q16
);

  logic [9:0]               cutoff_r, cutoff_nxt;
  logic signed [9:0]        zo_r, zo_nxt;
  logic signed [DP_W-1:0]   dp_r;
  logic [PER_W-1:0]         per_r;
  logic [C_W-1:0]           c_r;
  logic [CP_W-1:0]          cp_r;
  logic [K_W-1:0]           k_r;
  logic [ALPHA_W-1:0]       alpha_r;
  logic signed [FV_W:0]     diff_r;
  logic signed [49:0]       prod_r;
  logic signed [FV_W-1:0]   fv_r, fv_nxt;
  logic                     seeded_r, seeded_nxt;
  logic signed [DP_W-1:0]   filt_r;
  logic signed [CORR_W-1:0] corr_r;
  logic signed [CORR_W-1:0] raw_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [MNUM_W-1:0] num_r;
  logic signed [FLOW_W-1:0] flow_f_r;
  logic signed [FLOW_W-1:0] flow_w_r;
  logic                     out_valid_r;

  logic [9:0]               c_clamp;
  logic signed [CORR_W-1:0] x;
  logic [IDX_W-1:0]         idx_p1;
  logic signed [CAL_DP_W-1:0] d0, d1;
  logic signed [CAL_Q_W-1:0]  q0, q1;
  logic signed [CAL_DP_W:0] dx;
  logic signed [CAL_Q_W:0]  dq;
  logic signed [CORR_W:0]   xoff;
  logic [MNUM_W-1:0]        num_abs;
  logic [DEN_W-1:0]         den_a;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_start;
  logic                     div_busy;
  logic [QUO_W-1:0]         div_quo;
  logic signed [49:0]       prod_rnd;
  logic signed [FV_W:0]     fv_rnd;
  logic signed [18:0]       qsum;
  logic signed [FLOW_W-1:0] qsat;
  logic signed [9:0]        cfg_s;

  assign cfg_s = $signed(cfg_data);

  always_comb begin
    cutoff_nxt = cutoff_r;
    zo_nxt = zo_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_CUTOFF: cutoff_nxt = cfg_data;
        REG_ZERO: begin
          if (cfg_s > ZO_MAX) zo_nxt = ZO_MAX;
          else if (cfg_s < ZO_MIN) zo_nxt = ZO_MIN;
          else zo_nxt = cfg_s;
        end
        default: cutoff_nxt = cutoff_r;
      endcase
    end
  end

  always_comb begin
    if (cutoff_r < CUTOFF_MIN) c_clamp = CUTOFF_MIN;
    else if (cutoff_r > CUTOFF_MAX) c_clamp = CUTOFF_MAX;
    else c_clamp = cutoff_r;
  end

  assign x = cmd.x_sel ? raw_r : corr_r;
  assign idx_p1 = IDX_W'(idx_r + 1'b1);
  assign d0 = cal_dp(idx_r);
  assign d1 = cal_dp(idx_p1);
  assign q0 = cal_q(idx_r);
  assign q1 = cal_q(idx_p1);
  assign dx = {d1[CAL_DP_W-1], d1} - {d0[CAL_DP_W-1], d0};
  assign dq = {q1[CAL_Q_W-1], q1} - {q0[CAL_Q_W-1], q0};
  assign xoff = {x[CORR_W-1], x} - {{(CORR_W + 1 - CAL_DP_W){d0[CAL_DP_W-1]}}, d0};
  assign num_abs = num_r[MNUM_W-1] ? MNUM_W'(-num_r) : MNUM_W'(num_r);

  assign den_a = TIME_SCALE_Q16 + DEN_W'(k_r);
  assign div_start = cmd.div_alpha | cmd.div_map;
  always_comb begin
    if (cmd.div_alpha) begin
      div_num = NUM_W'({k_r, 16'b0}) + NUM_W'(den_a >> 1);
      div_den = den_a;
    end else begin
      div_num = NUM_W'(num_abs) + NUM_W'(dx[CAL_DP_W:1]);
      div_den = DEN_W'(dx);
    end
  end

  fdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign prod_rnd = prod_r + 50'sd32768;
  assign fv_rnd = {fv_r[FV_W-1], fv_r} + 33'sd32768;

  always_comb begin
    fv_nxt = fv_r;
    seeded_nxt = seeded_r;
    if (cmd.fupd) begin
      seeded_nxt = 1'b1;
      if (!seeded_r) fv_nxt = {dp_r, 16'b0};
      else fv_nxt = fv_r + prod_rnd[47:16];
    end
  end

  assign qsum = {{(19 - CAL_Q_W){q0[CAL_Q_W-1]}}, q0}
              + (num_r[MNUM_W-1] ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo}));
  always_comb begin
    if (qsum > 19'sd32767) qsat = 16'sh7fff;
    else if (qsum < -19'sd32768) qsat = -16'sh8000;
    else qsat = qsum[FLOW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dp_r <= in_dp_sample;
      per_r <= in_period_us;
      c_r <= c_clamp[C_W-1:0];
    end
    if (cmd.mul1) cp_r <= CP_W'(c_r) * CP_W'(per_r[16:0]);
    if (cmd.mul2) k_r <= K_W'(cp_r) * K_W'(TWO_PI_Q16);
    if (cmd.alpha_take) alpha_r <= div_quo[QUO_W-1] ? '1 : div_quo[ALPHA_W-1:0];
    if (cmd.diff) diff_r <= $signed({dp_r[DP_W-1], dp_r, 16'b0}) - {fv_r[FV_W-1], fv_r};
    if (cmd.fmul) prod_r <= diff_r * $signed({1'b0, alpha_r});
    if (cmd.fout) begin
      filt_r <= fv_rnd[31:16];
      corr_r <= {fv_rnd[31], fv_rnd[31:16]} - {{7{zo_r[9]}}, zo_r};
      raw_r <= {dp_r[DP_W-1], dp_r} - {{7{zo_r[9]}}, zo_r};
    end
    if (cmd.mmul) num_r <= MNUM_W'(xoff * dq);
    if (cmd.map_take) begin
      if (cmd.x_sel) flow_w_r <= qsat;
      else flow_f_r <= qsat;
    end
    if (cmd.out_load) begin
      out_dp_filtered <= filt_r;
      out_dp_corrected <= corr_r;
      out_flow_filtered <= flow_f_r;
      out_flow_raw <= flow_w_r;
      out_alpha_q16 <= alpha_r;
    end
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
      zo_r <= ZO_RESET;
      fv_r <= '0;
      seeded_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cutoff_r <= cutoff_nxt;
      zo_r <= zo_nxt;
      fv_r <= fv_nxt;
      seeded_r <= seeded_nxt;
      if (cmd.scan_clr) idx_r <= '0;
      else if (cmd.scan_inc) idx_r <= idx_p1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.in_valid = in_valid;
  assign sts.in_ok = (in_period_us != '0) && (in_period_us <= MAX_PERIOD_US);
  assign sts.div_busy = div_busy;
  assign sts.scan_hit = (x <= $signed({{(CORR_W - CAL_DP_W){d1[CAL_DP_W-1]}}, d1}))
                      || (idx_r == IDX_LAST);
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

// ===== rtl/core/fdc_ctrl.sv =====
// Sequencer: steps one sample through alpha, filter update and two
// calibration lookups. Depends on fdc_pkg.
module fdc_ctrl import fdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fdc_sts_t sts,
  output fdc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_ADIV  = 4'd3;
  localparam logic [3:0] S_AWAIT = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_FMUL  = 4'd6;
  localparam logic [3:0] S_FUPD  = 4'd7;
  localparam logic [3:0] S_FOUT  = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_MMUL  = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_MWAIT = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    cmd = '0;
    cmd.x_sel = pass_r;
    case (state_r)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.in_valid && sts.in_ok) begin
          cmd.load = 1'b1;
          pass_nxt = 1'b0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        cmd.div_alpha = 1'b1;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (!sts.div_busy) begin
          cmd.alpha_take = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        cmd.fmul = 1'b1;
        state_nxt = S_FUPD;
      end
      S_FUPD: begin
        cmd.fupd = 1'b1;
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        cmd.fout = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_hit) state_nxt = S_MMUL;
        else cmd.scan_inc = 1'b1;
      end
      S_MMUL: begin
        cmd.mmul = 1'b1;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_map = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts.div_busy) begin
          cmd.map_take = 1'b1;
          if (!pass_r) begin
            pass_nxt = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a word still waiting");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_alpha || cmd.div_map) |-> !sts.div_busy)
    else $error("divider restarted while busy");
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (sts.in_ok && cmd.ready))
    else $error("rejected sample loaded");

endmodule

// ===== rtl/core/flow_dp_filter_and_calibrate_core.sv =====
// Top level of the flow conditioning core: IIR low-pass plus table
// calibration. Depends on fdc_pkg, fdc_in_if, fdc_out_if, fdc_ctrl, fdc_dpath.
//
//  channel  | dir | handshake           | contents
//  in_ch    | in  | valid/ready         | dp_sample, period_us
//  out_ch   | out | valid/ready         | dp_filtered, dp_corrected, flow_*, alpha_q16
//  cfg_*    | in  | cfg_we, no wait     | cfg_idx selects cutoff or zero offset
//
// Each sample makes three divider passes (alpha, then the interpolation of each
// flow value) plus a table scan per flow value. Samples with a bad period are
// taken and dropped, no word.
// Synchronous active-low reset clears filter state and loads register defaults.
// A stalled result sits in the output register while the next sample is taken.
module flow_dp_filter_and_calibrate_core import fdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fdc_in_if.sink                in_ch,
  fdc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fdc_cmd_t cmd;
  fdc_sts_t sts;

  fdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  fdc_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_ch.valid),
    .in_dp_sample      (in_ch.dp_sample),
    .in_period_us      (in_ch.period_us),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_dp_filtered   (out_ch.dp_filtered),
    .out_dp_corrected  (out_ch.dp_corrected),
    .out_flow_filtered (out_ch.flow_filtered),
    .out_flow_raw      (out_ch.flow_raw),
    .out_alpha_q16     (out_ch.alpha_q16)
  );

  assign in_ch.ready = cmd.ready;

endmodule

// ===== bench/tb_flow_dp_filter_and_calibrate_core.sv =====
// Self-checking bench for flow_dp_filter_and_calibrate_core: directed table, then
// random samples over several register settings, checked against an in-bench predictor.
// Depends on fdc_pkg, fdc_in_if, fdc_out_if and the core itself.
module tb_flow_dp_filter_and_calibrate_core;
  import fdc_pkg::*;

  typedef struct packed {
    logic signed [DP_W-1:0]   dp_filtered;
    logic signed [CORR_W-1:0] dp_corrected;
    logic signed [FLOW_W-1:0] flow_filtered;
    logic signed [FLOW_W-1:0] flow_raw;
    logic [ALPHA_W-1:0]       alpha_q16;
  } flow_word_t;

  typedef struct {
    logic signed [DP_W-1:0] dp;
    logic [PER_W-1:0]       per;
    bit                     gives_word;
  } sample_row_t;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;

  localparam int CAL_X [TABLE_POINTS] = '{
    -4720, -3990, -3330, -2740, -2200, -1720, -1260, -890, -580, -340,
    -155, -40, 0, 55, 168, 366, 623, 955, 1380, 1880,
    2450, 3075, 3770, 4620, 5340};
  localparam int CAL_Y [TABLE_POINTS] = '{
    -1210, -1100, -990, -880, -780, -670, -548, -438, -330, -230,
    -131, -49, 0, 50, 132, 232, 334, 442, 552, 673,
    770, 880, 985, 1090, 1200};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_CUTOFF;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fdc_in_if in_ch();
  fdc_out_if out_ch();

  flow_dp_filter_and_calibrate_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned cutoff_q = 100;
  int          zero_q = -20;
  int          iir_state = 0;
  bit          iir_loaded = 1'b0;

  flow_word_t flow_pending_q[$];
  int mismatches = 0;
  int words_seen = 0;
  int samples_sent = 0;
  int samples_dropped = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_mode = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int rcv_cnt = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.dp_sample = '0;
    in_ch.period_us = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [FLOW_W-1:0] pressure_to_flow(longint x);
    int a;
    longint q;
    a = 0;
    if (x <= CAL_X[0]) a = 0;
    else if (x >= CAL_X[TABLE_POINTS-1]) a = TABLE_POINTS - 2;
    else begin
      while (x > CAL_X[a+1]) a++;
    end
    q = CAL_Y[a] + div_near((x - CAL_X[a]) * (CAL_Y[a+1] - CAL_Y[a]),
                            CAL_X[a+1] - CAL_X[a]);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[FLOW_W-1:0];
  endfunction

  task automatic predict_flow(input logic signed [DP_W-1:0] dp, input logic [PER_W-1:0] per,
                              output bit ok, output flow_word_t w);
    longint unsigned c, k, den, al;
    longint x, y, diff, filt, corr;
    ok = 1'b0;
    w = '0;
    if (per == 0 || per > MAX_PERIOD_US) return;
    ok = 1'b1;
    c = cutoff_q;
    if (c < 1) c = 1;
    if (c > 500) c = 500;
    k = c * longint'(per) * 64'd411775;
    den = 64'd655360000000 + k;
    al = ((k << 16) + den / 2) / den;
    if (al > 65535) al = 65535;
    x = dp;
    if (!iir_loaded) begin
      y = x * 65536;
      iir_loaded = 1'b1;
    end else begin
      diff = x * 65536 - longint'(iir_state);
      y = longint'(iir_state) + ((diff * longint'(al) + 32768) >>> 16);
    end
    iir_state = int'(y);
    filt = (y + 32768) >>> 16;
    corr = filt - zero_q;
    w.dp_filtered = filt[DP_W-1:0];
    w.dp_corrected = corr[CORR_W-1:0];
    w.flow_filtered = pressure_to_flow(corr);
    w.flow_raw = pressure_to_flow(x - zero_q);
    w.alpha_q16 = al[ALPHA_W-1:0];
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int v;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CUTOFF) cutoff_q = val;
    else begin
      v = int'($signed(val));
      if (v > 500) v = 500;
      if (v < -500) v = -500;
      zero_q = v;
    end
  endtask

  task automatic send_sample(input logic signed [DP_W-1:0] dp, input logic [PER_W-1:0] per,
                             output bit ok);
    flow_word_t w;
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.dp_sample <= dp;
    in_ch.period_us <= per;
    do @(posedge clk); while (!in_ch.ready);
    predict_flow(dp, per, ok, w);
    if (ok) flow_pending_q.push_back(w);
    else samples_dropped++;
    samples_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (flow_pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PER_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return PER_W'($urandom_range(100001, 262143));
    if (r < 20) return (r < 17) ? 18'd100000 : 18'd1;
    if (r < 35) return PER_W'($urandom_range(1, 100000));
    return PER_W'($urandom_range(500, 20000));
  endfunction

  function automatic logic signed [DP_W-1:0] pick_pressure();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return DP_W'($urandom());
    if (r < 80) return DP_W'(int'($urandom_range(0, 10600)) - 5300);
    if (r < 90) return DP_W'(int'($urandom_range(0, 200)) - 100);
    return (r < 95) ? 16'sh7fff : 16'sh8000;
  endfunction

  // result sink
  always @(negedge clk) begin
    rcv_cnt++;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (holds_done < hold_reqs) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ((rcv_cnt % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    flow_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (flow_pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", {out_ch.dp_filtered,
          out_ch.dp_corrected, out_ch.flow_filtered, out_ch.flow_raw, out_ch.alpha_q16});
      end else begin
        exp_w = flow_pending_q.pop_front();
        if (out_ch.dp_filtered !== exp_w.dp_filtered ||
            out_ch.dp_corrected !== exp_w.dp_corrected ||
            out_ch.flow_filtered !== exp_w.flow_filtered ||
            out_ch.flow_raw !== exp_w.flow_raw ||
            out_ch.alpha_q16 !== exp_w.alpha_q16) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d mismatch: exp filt %0d corr %0d ff %0d fr %0d a %0d / got %0d %0d %0d %0d %0d",
              words_seen, exp_w.dp_filtered, exp_w.dp_corrected, exp_w.flow_filtered,
              exp_w.flow_raw, exp_w.alpha_q16, out_ch.dp_filtered, out_ch.dp_corrected,
              out_ch.flow_filtered, out_ch.flow_raw, out_ch.alpha_q16);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d words outstanding", flow_pending_q.size());
      $display("tb_flow_dp_filter_and_calibrate_core: errors");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    bit ok;
    int ph, n;
    logic [CFG_DATA_W-1:0] cut_set [7];
    logic [CFG_DATA_W-1:0] zero_set [7];

    cut_set = '{10'd100, 10'd0, 10'd1023, 10'd1, 10'd500, 10'd1000, 10'd37};
    zero_set = '{10'h3ec, 10'h1ff, 10'h200, 10'd0, 10'h20c, 10'd500, 10'd3};
    rows = '{
      '{16'sd0, 18'd0, 1'b0}, '{16'sd100, 18'd100001, 1'b0},
      '{16'sd0, 18'd1000, 1'b1}, '{16'sh7fff, 18'd1000, 1'b1},
      '{16'sh8000, 18'd1000, 1'b1}, '{16'sh7fff, 18'd262143, 1'b0},
      '{16'sh7fff, 18'd100000, 1'b1}, '{16'sh8000, 18'd1, 1'b1},
      '{-16'sd4720, 18'd5000, 1'b1}, '{16'sd5340, 18'd5000, 1'b1},
      '{-16'sd6000, 18'd5000, 1'b1}, '{16'sd9000, 18'd5000, 1'b1},
      '{16'sd55, 18'd2000, 1'b1}, '{-16'sd40, 18'd2000, 1'b1},
      '{16'sd0, 18'd0, 1'b0}, '{16'sh5555, 18'h2aaaa, 1'b0},
      '{-16'sh5556, 18'h15555, 1'b1}, '{16'sd1, 18'd100000, 1'b1}};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_sample(rows[i].dp, rows[i].per, ok);
      if (ok != rows[i].gives_word) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d: word presence exp %0b", i, rows[i].gives_word);
      end
    end
    drain_and_settle();

    for (ph = 0; ph < 7; ph++) begin
      write_reg(REG_CUTOFF, cut_set[ph]);
      write_reg(REG_ZERO, zero_set[ph]);
      stall_mode = ph % 3;
      gaps_on = (ph != 4);
      if (ph == 2) hold_reqs++;
      for (n = 0; n < 105; n++) send_sample(pick_pressure(), pick_period(), ok);
      drain_and_settle();
    end

    $display("%0d samples sent (%0d rejected for period), %0d words checked",
             samples_sent, samples_dropped, words_seen);
    $display("7 register settings incl. clamped cutoff and offset extremes, one long sink hold");
    if (mismatches == 0 && flow_pending_q.size() == 0)
      $display("tb_flow_dp_filter_and_calibrate_core: clean");
    else
      $display("tb_flow_dp_filter_and_calibrate_core: errors");
    $finish;
  end
endmodule
